// ===== hdl/kv_workload_draw_sampler_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the workload draw sampler
// Each check fires on the rising edge of clk and is held off while rst_n is
// low. In synthesis the macros expand to nothing.
// ----------------------------------------------------------------------------
`ifndef KV_WORKLOAD_DRAW_SAMPLER_ASSERT_SVH
`define KV_WORKLOAD_DRAW_SAMPLER_ASSERT_SVH

`ifndef SYNTHESIS
// The condition must hold at every clock edge outside reset.
`define KVWDS_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// When the trigger holds, the consequence must hold in the next cycle.
`define KVWDS_ASSERT_NEXT(lbl, trig, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) else $error(msg);
`else
`define KVWDS_ASSERT_ALWAYS(lbl, cond, msg)
`define KVWDS_ASSERT_NEXT(lbl, trig, cons, msg)
`endif

`endif

// ===== hdl/kvwds_pkg.sv =====
// ----------------------------------------------------------------------------
// kvwds_pkg
// Sizes, field layouts and codes shared by the workload draw sampler.
// ----------------------------------------------------------------------------
`default_nettype none

package kvwds_pkg;

    // Table depth and the fixed-point format of all fractions.
    localparam int MAX_KEYS      = 1024;
    localparam int FRACTION_BITS = 16;

    localparam int KEY_W   = $clog2(MAX_KEYS);   // key index width
    localparam int CNT_W   = KEY_W + 1;          // holds MAX_KEYS itself
    localparam int CDF_W   = FRACTION_BITS + 1;  // 1.0 is representable
    localparam int RAND_W  = FRACTION_BITS;
    localparam int KIND_W  = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 17;

    // Input tdata layout, lowest bit first.
    localparam int IN_ENTRY_LSB = 0;
    localparam int IN_CDF_LSB   = IN_ENTRY_LSB + 10;
    localparam int IN_KRAND_LSB = IN_CDF_LSB + 17;
    localparam int IN_ORAND_LSB = IN_KRAND_LSB + 16;
    localparam int IN_BITS      = IN_ORAND_LSB + 16;
    localparam int IN_DATA_W    = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_W   = ((KEY_W + 7) / 8) * 8;

    // Item kinds on the input tuser.
    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_DRAW = 1'b1;

    // Operation kinds.
    localparam logic [KIND_W-1:0] KIND_GET = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PUT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DEL = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_KEY_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_DIST  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GET_SHARE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PUT_SHARE = 2'd3;

endpackage

`default_nettype wire

// ===== hdl/kvwds_ram.sv =====
// ----------------------------------------------------------------------------
// kvwds_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module kvwds_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== hdl/kv_workload_draw_sampler.sv =====
// ----------------------------------------------------------------------------
// kv_workload_draw_sampler
// Turns random words into key-value requests: a key index and an operation.
// ----------------------------------------------------------------------------
// Usage. Input transactions arrive on the s_axis group. A transaction with
// tuser low is a load: it writes one entry of the cumulative distribution
// table and produces no output. A transaction with tuser high is a draw: it
// produces exactly one output transaction on the m_axis group carrying the
// key index in tdata and the operation kind in tuser.
// Sequencing. A load leaves the sequencer in its idle state, ready for the
// next input transaction. A uniform draw passes through the uniform state,
// which registers its key, and the finish state, which loads the output
// register. A zipf draw performs a binary search over the table with one
// table read per cycle, so it takes up to floor(log2(n)) + 1 reads for n
// active keys; its result is then loaded into the output register from the
// finish state. With 1024 keys the search takes 10 or 11 reads. The table
// memory has a single read port, so the search issues one read at a time.
// One item is in progress at a time.
// Reset. Configuration registers return to 1024 keys, uniform mode, all
// GET. The table memory is not cleared; every entry that a zipf draw can
// reach must be loaded before such a draw is issued.
// Stalls. The finished result sits in an output register; the next input
// transaction is taken while it waits. A new draw that completes while the
// previous result is still unaccepted holds until the output frees up.
// ----------------------------------------------------------------------------
`default_nettype none

`include "kv_workload_draw_sampler_assert.svh"

module kv_workload_draw_sampler (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // Configuration write port.
    input  wire logic                               cfg_we,
    input  wire logic [kvwds_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [kvwds_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    // Input stream.
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // tdata: entry_index[9:0], cdf_value[26:10], key_random[42:27],
    //        op_random[58:43], zero fill up to bit 63
    input  wire logic [kvwds_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // tuser: mode[0]
    input  wire logic                               s_axis_tuser,
    // Output stream.
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // tdata: key_index[9:0], zero fill up to bit 15
    output logic [kvwds_pkg::OUT_DATA_W-1:0]        m_axis_tdata,
    // tuser: op_kind[1:0]
    output logic [kvwds_pkg::KIND_W-1:0]            m_axis_tuser
);

    localparam int KEY_W  = kvwds_pkg::KEY_W;
    localparam int CNT_W  = kvwds_pkg::CNT_W;
    localparam int CDF_W  = kvwds_pkg::CDF_W;
    localparam int RAND_W = kvwds_pkg::RAND_W;
    localparam int KIND_W = kvwds_pkg::KIND_W;
    localparam int PROD_W = RAND_W + CNT_W;

    // Sequencer states.
    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_UNIF   = 2'd1;
    localparam logic [1:0] ST_SEARCH = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    // Configuration registers.
    logic [CNT_W-1:0]  key_count_reg;
    logic              key_dist_reg;
    logic [CDF_W-1:0]  get_share_reg;
    logic [CDF_W-1:0]  put_share_reg;

    // Control state.
    logic [1:0]        state_reg, state_next;
    logic              pend_reg, pend_next;
    logic              m_valid_reg, m_valid_next;

    // Per-draw working registers.
    logic [CNT_W-1:0]  n_reg, n_next;
    logic [RAND_W-1:0] r_reg, r_next;
    logic [KIND_W-1:0] kind_reg, kind_next;
    logic [CNT_W-1:0]  lo_reg, lo_next;
    logic [CNT_W-1:0]  hi_reg, hi_next;
    logic [KEY_W-1:0]  mid_reg, mid_next;
    logic [KEY_W-1:0]  res_key_reg, res_key_next;
    logic [KEY_W-1:0]  m_key_reg, m_key_next;
    logic [KIND_W-1:0] m_kind_reg, m_kind_next;

    // Input field views.
    logic                 in_acc;
    logic                 in_mode;
    logic [KEY_W-1:0]     in_entry;
    logic [CDF_W-1:0]     in_cdf;
    logic [RAND_W-1:0]    in_krand;
    logic [RAND_W-1:0]    in_orand;
    logic [RAND_W-1:0]    krand_adj;
    logic [CNT_W-1:0]     n_active;
    logic [KIND_W-1:0]    kind_calc;
    logic [CDF_W:0]       get_put_sum;

    // Search datapath.
    logic [CDF_W-1:0]     ram_rdata;
    logic                 ram_we;
    logic                 cmp_ge;
    logic [CNT_W-1:0]     lo_upd, hi_upd, span, mid_calc;
    logic                 search_more;

    // Uniform datapath.
    logic [PROD_W-1:0]    prod;
    logic [CNT_W-1:0]     ukey;

    logic                 out_load;

    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign in_mode  = s_axis_tuser;
    assign in_entry = s_axis_tdata[kvwds_pkg::IN_ENTRY_LSB +: KEY_W];
    assign in_cdf   = s_axis_tdata[kvwds_pkg::IN_CDF_LSB +: CDF_W];
    assign in_krand = s_axis_tdata[kvwds_pkg::IN_KRAND_LSB +: RAND_W];
    assign in_orand = s_axis_tdata[kvwds_pkg::IN_ORAND_LSB +: RAND_W];

    // One item at a time; the output register decouples the receiver.
    assign s_axis_tready = (state_reg == ST_IDLE);

    // A zero key random is treated as the smallest non-zero fraction.
    assign krand_adj = (in_krand == '0) ? RAND_W'(1) : in_krand;

    // Clamp the key count into the range that the table supports.
    always_comb
    begin
        if (key_count_reg == '0)
        begin
            n_active = CNT_W'(1);
        end
        else if (key_count_reg > CNT_W'(kvwds_pkg::MAX_KEYS))
        begin
            n_active = CNT_W'(kvwds_pkg::MAX_KEYS);
        end
        else
        begin
            n_active = key_count_reg;
        end
    end

    // Operation kind: below the GET share is GET, below GET plus PUT is PUT.
    // The sum is kept at full width so shares above one need no care.
    assign get_put_sum = {1'b0, get_share_reg} + {1'b0, put_share_reg};

    always_comb
    begin
        if ({1'b0, in_orand} < get_share_reg)
        begin
            kind_calc = kvwds_pkg::KIND_GET;
        end
        else if ({2'b00, in_orand} < get_put_sum)
        begin
            kind_calc = kvwds_pkg::KIND_PUT;
        end
        else
        begin
            kind_calc = kvwds_pkg::KIND_DEL;
        end
    end

    // Table memory. Every 10-bit entry index lies inside the table, so a
    // load always writes.
    assign ram_we = in_acc && (in_mode == kvwds_pkg::MODE_LOAD);

    kvwds_ram #(
        .WIDTH (CDF_W),
        .DEPTH (kvwds_pkg::MAX_KEYS)
    ) u_cdf_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (in_entry),
        .wdata (in_cdf),
        .raddr (mid_calc[KEY_W-1:0]),
        .rdata (ram_rdata)
    );

    // One search step per cycle: fold in the entry read last cycle, then
    // present the next midpoint to the memory in the same cycle.
    always_comb
    begin
        cmp_ge = (ram_rdata >= {1'b0, r_reg});
        lo_upd = lo_reg;
        hi_upd = hi_reg;
        if (pend_reg)
        begin
            if (cmp_ge)
            begin
                hi_upd = {1'b0, mid_reg};
            end
            else
            begin
                lo_upd = {1'b0, mid_reg} + CNT_W'(1);
            end
        end
        span        = hi_upd - lo_upd;
        mid_calc    = lo_upd + (span >> 1);
        search_more = (lo_upd < hi_upd);
    end

    // Uniform key: scale the fraction by the key count and saturate.
    assign prod = r_reg * n_reg;
    assign ukey = prod[PROD_W-1:kvwds_pkg::FRACTION_BITS];

    assign out_load = (state_reg == ST_FINISH) && (!m_valid_reg || m_axis_tready);

    // Sequencer.
    always_comb
    begin
        state_next   = state_reg;
        pend_next    = pend_reg;
        n_next       = n_reg;
        r_next       = r_reg;
        kind_next    = kind_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        mid_next     = mid_reg;
        res_key_next = res_key_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && (in_mode == kvwds_pkg::MODE_DRAW))
                begin
                    n_next    = n_active;
                    r_next    = krand_adj;
                    kind_next = kind_calc;
                    lo_next   = '0;
                    hi_next   = n_active;
                    pend_next = 1'b0;
                    state_next = key_dist_reg ? ST_SEARCH : ST_UNIF;
                end
            end
            ST_UNIF:
            begin
                if (ukey >= n_reg)
                begin
                    res_key_next = KEY_W'(n_reg - CNT_W'(1));
                end
                else
                begin
                    res_key_next = ukey[KEY_W-1:0];
                end
                state_next = ST_FINISH;
            end
            ST_SEARCH:
            begin
                lo_next = lo_upd;
                hi_next = hi_upd;
                if (search_more)
                begin
                    mid_next  = mid_calc[KEY_W-1:0];
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                    // No entry reached the random value: take the last key.
                    if (lo_upd >= n_reg)
                    begin
                        res_key_next = KEY_W'(n_reg - CNT_W'(1));
                    end
                    else
                    begin
                        res_key_next = lo_upd[KEY_W-1:0];
                    end
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register.
    always_comb
    begin
        m_valid_next = m_valid_reg;
        m_key_next   = m_key_reg;
        m_kind_next  = m_kind_reg;
        if (out_load)
        begin
            m_valid_next = 1'b1;
            m_key_next   = res_key_reg;
            m_kind_next  = kind_reg;
        end
        else if (m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    // Control and configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pend_reg      <= 1'b0;
            m_valid_reg   <= 1'b0;
            key_count_reg <= CNT_W'(kvwds_pkg::MAX_KEYS);
            key_dist_reg  <= 1'b0;
            get_share_reg <= CDF_W'(1) << kvwds_pkg::FRACTION_BITS;
            put_share_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    kvwds_pkg::REG_KEY_COUNT: key_count_reg <= cfg_wdata[CNT_W-1:0];
                    kvwds_pkg::REG_KEY_DIST:  key_dist_reg  <= cfg_wdata[0];
                    kvwds_pkg::REG_GET_SHARE: get_share_reg <= cfg_wdata[CDF_W-1:0];
                    kvwds_pkg::REG_PUT_SHARE: put_share_reg <= cfg_wdata[CDF_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        n_reg       <= n_next;
        r_reg       <= r_next;
        kind_reg    <= kind_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        mid_reg     <= mid_next;
        res_key_reg <= res_key_next;
        m_key_reg   <= m_key_next;
        m_kind_reg  <= m_kind_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {{(kvwds_pkg::OUT_DATA_W - KEY_W){1'b0}}, m_key_reg};
    assign m_axis_tuser  = m_kind_reg;

    // The search window never inverts and never leaves the active keys.
    `KVWDS_ASSERT_ALWAYS(a_search_window, (state_reg != ST_SEARCH) || ((lo_reg <= hi_reg) && (hi_reg <= n_reg)), "search window out of range")
    // A uniform draw finishes next cycle with a key below the key count.
    `KVWDS_ASSERT_NEXT(a_uniform_key, state_reg == ST_UNIF, (state_reg == ST_FINISH) && ({1'b0, res_key_reg} < n_reg), "uniform key not below key count")
    // Only the three defined operation kinds are ever presented.
    `KVWDS_ASSERT_ALWAYS(a_kind_code, !m_axis_tvalid || (m_axis_tuser != 2'd3), "undefined operation kind on output")

endmodule

`default_nettype wire
